/* src/fit_block_allocator_defines.svh */
// ----------------------------------------------------------------------------
// fit_block_allocator_defines.svh
// Assertion macros shared by the allocator RTL. They expect clk and rst_n in
// scope.
// ----------------------------------------------------------------------------
`ifndef FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define FBA_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("fit_block_allocator: invariant check failed");

// Condition that must hold in the cycle after the trigger.
`define FBA_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("fit_block_allocator: sequence check failed");

`endif

/* src/fba_pkg.sv */
// ----------------------------------------------------------------------------
// fba_pkg
// Constants, codes and word types of the fit block allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

    // Pool geometry (block size is a power of two)
    localparam int NUM_BLOCKS  = 64;
    localparam int BLOCK_BYTES = 8;

    localparam int ADDR_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W    = $clog2(NUM_BLOCKS + 1);
    localparam int SCAN_W   = $clog2(NUM_BLOCKS + 2);
    localparam int BB_SHIFT = $clog2(BLOCK_BYTES);

    // Field widths
    localparam int CMD_W    = 2;
    localparam int SIZE_W   = 16;
    localparam int IDX_W    = 6;
    localparam int STATUS_W = 2;
    localparam int START_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int BYTES_W  = 4;
    localparam int NEED_W   = SIZE_W - BB_SHIFT + 1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE_ALL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NOT_HEAD = 2'd2;
    localparam logic [STATUS_W-1:0] STS_BAD_SIZE = 2'd3;

    // Fit strategies
    localparam logic [1:0] STRAT_FIRST = 2'd0;
    localparam logic [1:0] STRAT_BEST  = 2'd1;
    localparam logic [1:0] STRAT_WORST = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_FREE_HEAD,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_QUERY,
        ST_DONE
    } fba_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SIZE_W-1:0] size_bytes;
        logic [IDX_W-1:0]  block_index;
    } fba_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  start_block;
        logic [COUNT_W-1:0]  blocks_count;
        logic [COUNT_W-1:0]  free_blocks;
        logic                query_allocated;
        logic [BYTES_W-1:0]  query_bytes;
    } fba_rsp_t;

    // One block table entry as held in the RAM
    typedef struct packed {
        logic              in_use;
        logic              is_head;
        logic [ADDR_W-1:0] owner;
        logic [BYTES_W-1:0] bytes;
    } fba_entry_t;

    localparam int ENTRY_W = $bits(fba_entry_t);

    // Sequencer to fit search
    typedef struct packed {
        logic              init;
        logic              step;
        logic              end_run;
        logic              last;
        logic [SCAN_W-1:0] idx;
    } fba_fit_ctl_t;

    // Fit search to sequencer
    typedef struct packed {
        logic              done;
        logic              found;
        logic [ADDR_W-1:0] start;
    } fba_fit_res_t;

endpackage

/* src/fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// fit_block_allocator
// Block pool allocator with first, best and worst fit. The block table sits
// in one RAM; a sequencer scans and writes it one entry per cycle and walks it.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Word
//  cmd     | in        | cmd_valid/cmd_stall  | fba_cmd_t
//  rsp     | out       | rsp_valid/rsp_stall  | fba_rsp_t
//  cfg     | in        | cfg_we               | fit_strategy, 2 bits
//
//  Allocate: a table scan over the RAM read port (one entry a cycle), then
//    the write of the run; first fit ends the scan at the first run that fits.
//  Free: reads the head, then reads and checks each trailing block of the run
//    and the block past the run, which is not read when the run ends at the
//    top block; a block that is not a head ends the free at the head read.
//  Query reads at most one entry. Free all, bad size and oversize skip the RAM.
//  Reset clears the per-block valid flags at once; no clearing pass.
//  A stalled result waits in the output register while the next word is
//    taken; a second finished result waits in the sequencer until it drains.
// ----------------------------------------------------------------------------
`include "fit_block_allocator_defines.svh"

module fit_block_allocator
    import fba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  fba_cmd_t   cmd,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output fba_rsp_t   rsp,
    input  logic       cfg_we,
    input  logic [1:0] cfg_data
);

    // Control state
    fba_state_t            state_reg, state_next;
    logic [1:0]            strategy_reg;
    logic [CNT_W-1:0]      free_total_reg, free_total_next;
    logic [NUM_BLOCKS-1:0] valid_reg, valid_next;
    logic                  valid_q_reg, valid_q_next;
    logic [SCAN_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                  pend_reg, pend_next;
    logic [SCAN_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [SCAN_W-1:0]     wr_k_reg, wr_k_next;
    logic [SCAN_W-1:0]     x_reg, x_next;
    logic [SCAN_W-1:0]     count_reg, count_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    // Payload
    fba_cmd_t              cmd_reg, cmd_next;
    logic [SCAN_W-1:0]     need_reg, need_next;
    logic [BYTES_W-1:0]    rem_reg, rem_next;
    logic [ADDR_W-1:0]     start_reg, start_next;
    fba_rsp_t              res_reg, res_next;
    fba_rsp_t              rsp_reg;
    fba_rsp_t              rsp_word;
    logic                  rsp_load;

    // RAM port
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    fba_entry_t            ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    fba_entry_t            rd_entry;
    logic                  rd_used;

    // Fit search
    fba_fit_ctl_t          fit_ctl;
    fba_fit_res_t          fit_res;

    // Decode helpers
    logic [NEED_W-1:0]     need_full;
    logic                  idx_in_range;
    logic [ADDR_W-1:0]     idx_addr;
    logic [ADDR_W-1:0]     x_addr;
    logic [ADDR_W-1:0]     wr_addr;

    fba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fba_fit u_fit (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (fit_ctl),
        .need     (need_reg),
        .strategy (strategy_reg),
        .res      (fit_res)
    );

    // Port side
    assign cmd_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Read data and decode
    always_comb
    begin
        rd_entry     = fba_entry_t'(ram_rdata);
        rd_used      = valid_q_reg && rd_entry.in_use;
        need_full    = NEED_W'((32'(cmd.size_bytes) + BLOCK_BYTES - 1) >> BB_SHIFT);
        idx_in_range = (32'(cmd.block_index) < NUM_BLOCKS);
        idx_addr     = ADDR_W'(cmd_reg.block_index);
        x_addr       = ADDR_W'(x_reg);
        wr_addr      = start_reg + ADDR_W'(wr_k_reg);
        // outgoing word with the current free count
        rsp_word             = res_reg;
        rsp_word.free_blocks = COUNT_W'(free_total_reg);
    end

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next      = state_reg;
        free_total_next = free_total_reg;
        valid_next      = valid_reg;
        scan_cnt_next   = scan_cnt_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        wr_k_next       = wr_k_reg;
        x_next          = x_reg;
        count_next      = count_reg;
        cmd_next        = cmd_reg;
        need_next       = need_reg;
        rem_next        = rem_reg;
        start_next      = start_reg;
        res_next        = res_reg;
        rsp_load        = 1'b0;

        ram_we          = 1'b0;
        ram_waddr       = wr_addr;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        fit_ctl         = '0;
        fit_ctl.idx     = pend_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    res_next = '0;
                    case (cmd.command)
                        CMD_ALLOC:
                        begin
                            if (cmd.size_bytes == '0)
                            begin
                                res_next.status = STS_BAD_SIZE;
                                state_next      = ST_DONE;
                            end
                            else if ((32'(need_full) > 32'(free_total_reg)) ||
                                     (32'(need_full) > NUM_BLOCKS))
                            begin
                                res_next.status = STS_NO_SPACE;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                need_next     = SCAN_W'(need_full);
                                rem_next      = BYTES_W'(cmd.size_bytes &
                                                SIZE_W'(BLOCK_BYTES - 1));
                                fit_ctl.init  = 1'b1;
                                scan_cnt_next = '0;
                                pend_next     = 1'b0;
                                state_next    = ST_SCAN;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (!idx_in_range)
                            begin
                                res_next.status = STS_NOT_HEAD;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = ADDR_W'(cmd.block_index);
                                state_next = ST_FREE_HEAD;
                            end
                        end
                        CMD_FREE_ALL:
                        begin
                            res_next.blocks_count =
                                COUNT_W'(CNT_W'(NUM_BLOCKS) - free_total_reg);
                            valid_next      = '0;
                            free_total_next = CNT_W'(NUM_BLOCKS);
                            state_next      = ST_DONE;
                        end
                        CMD_QUERY:
                        begin
                            if (idx_in_range)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = ADDR_W'(cmd.block_index);
                                state_next = ST_QUERY;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // issue side: one read per cycle, plus the pool-end marker
                if (scan_cnt_reg <= SCAN_W'(NUM_BLOCKS))
                begin
                    if (scan_cnt_reg < SCAN_W'(NUM_BLOCKS))
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = ADDR_W'(scan_cnt_reg);
                    end
                    pend_next     = 1'b1;
                    pend_idx_next = scan_cnt_reg;
                    scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // process side: entry read last cycle
                fit_ctl.step    = pend_reg;
                fit_ctl.last    = (pend_idx_reg == SCAN_W'(NUM_BLOCKS));
                fit_ctl.end_run = fit_ctl.last || rd_used;

                if (fit_res.done)
                begin
                    pend_next = 1'b0;
                    if (fit_res.found)
                    begin
                        start_next = fit_res.start;
                        wr_k_next  = '0;
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        res_next.status = STS_NO_SPACE;
                        state_next      = ST_DONE;
                    end
                end
            end

            ST_WRITE:
            begin
                ram_we            = 1'b1;
                ram_wdata.in_use  = 1'b1;
                ram_wdata.is_head = (wr_k_reg == '0);
                ram_wdata.owner   = start_reg;
                if ((wr_k_reg + SCAN_W'(1) == need_reg) && (rem_reg != '0))
                begin
                    ram_wdata.bytes = rem_reg;
                end
                else
                begin
                    ram_wdata.bytes = BYTES_W'(BLOCK_BYTES);
                end
                valid_next[wr_addr] = 1'b1;
                wr_k_next = wr_k_reg + SCAN_W'(1);

                if (wr_k_reg + SCAN_W'(1) == need_reg)
                begin
                    free_total_next       = free_total_reg - CNT_W'(need_reg);
                    res_next.status       = STS_OK;
                    res_next.start_block  = START_W'(start_reg);
                    res_next.blocks_count = COUNT_W'(need_reg);
                    state_next            = ST_DONE;
                end
            end

            ST_FREE_HEAD:
            begin
                if (!(valid_q_reg && rd_entry.is_head))
                begin
                    res_next.status = STS_NOT_HEAD;
                    state_next      = ST_DONE;
                end
                else
                begin
                    valid_next[idx_addr] = 1'b0;
                    count_next = SCAN_W'(1);
                    x_next     = SCAN_W'(idx_addr) + SCAN_W'(1);
                    state_next = ST_FREE_RD;
                end
            end

            ST_FREE_RD:
            begin
                if (x_reg >= SCAN_W'(NUM_BLOCKS))
                begin
                    free_total_next       = free_total_reg + CNT_W'(count_reg);
                    res_next.blocks_count = COUNT_W'(count_reg);
                    state_next            = ST_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = x_addr;
                    state_next = ST_FREE_CHK;
                end
            end

            ST_FREE_CHK:
            begin
                // tail block: in use, not a head, owned by the freed head
                if (rd_used && !rd_entry.is_head && (rd_entry.owner == idx_addr))
                begin
                    valid_next[x_addr] = 1'b0;
                    count_next = count_reg + SCAN_W'(1);
                    x_next     = x_reg + SCAN_W'(1);
                    state_next = ST_FREE_RD;
                end
                else
                begin
                    free_total_next       = free_total_reg + CNT_W'(count_reg);
                    res_next.blocks_count = COUNT_W'(count_reg);
                    state_next            = ST_DONE;
                end
            end

            ST_QUERY:
            begin
                if (rd_used)
                begin
                    res_next.query_allocated = 1'b1;
                    res_next.query_bytes     = rd_entry.bytes;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        valid_q_next   = ram_re ? valid_reg[ram_raddr] : valid_q_reg;
        rsp_valid_next = rsp_load || (rsp_valid_reg && rsp_stall);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_total_reg <= CNT_W'(NUM_BLOCKS);
            valid_reg      <= '0;
            valid_q_reg    <= 1'b0;
            scan_cnt_reg   <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            wr_k_reg       <= '0;
            x_reg          <= '0;
            count_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_total_reg <= free_total_next;
            valid_reg      <= valid_next;
            valid_q_reg    <= valid_q_next;
            scan_cnt_reg   <= scan_cnt_next;
            pend_reg       <= pend_next;
            pend_idx_reg   <= pend_idx_next;
            wr_k_reg       <= wr_k_next;
            x_reg          <= x_next;
            count_reg      <= count_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Strategy register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strategy_reg <= STRAT_FIRST;
        end
        else if (cfg_we)
        begin
            strategy_reg <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        need_reg  <= need_next;
        rem_reg   <= rem_next;
        start_reg <= start_next;
        res_reg   <= res_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_word;
        end
    end

    // Checks
    `FBA_ASSERT(a_free_bound, free_total_reg <= CNT_W'(NUM_BLOCKS))
    `FBA_ASSERT(a_write_in_write_state, !ram_we || (state_reg == ST_WRITE))
    `FBA_ASSERT_NEXT(a_accept_leaves_idle, cmd_valid && !cmd_stall, state_reg != ST_IDLE)
    `FBA_ASSERT(a_query_bytes_set, !(rsp_valid_reg && rsp_reg.query_allocated) || (rsp_reg.query_bytes != '0))

endmodule

/* src/fba_ram.sv */
// ----------------------------------------------------------------------------
// fba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/fba_fit.sv */
// ----------------------------------------------------------------------------
// fba_fit
// Run tracker for the fit search: follows free runs one block per step and
// keeps the first, smallest or largest run that holds the request.
// ----------------------------------------------------------------------------
module fba_fit
    import fba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  fba_fit_ctl_t      ctl,
    input  logic [SCAN_W-1:0] need,
    input  logic [1:0]        strategy,
    output fba_fit_res_t      res
);

    logic [SCAN_W-1:0] run_reg, run_next;
    logic              found_reg, found_next;
    logic [SCAN_W-1:0] best_len_reg, best_len_next;
    logic [ADDR_W-1:0] best_start_reg, best_start_next;

    logic              first;
    logic              better;
    logic              take;
    logic [SCAN_W-1:0] run_inc;
    logic [SCAN_W-1:0] run_start;
    logic [SCAN_W-1:0] hit_start;

    // Step logic
    always_comb
    begin
        first     = (strategy != STRAT_BEST) && (strategy != STRAT_WORST);
        run_inc   = run_reg + SCAN_W'(1);
        better    = (strategy == STRAT_BEST) ? (run_reg < best_len_reg)
                                             : (run_reg > best_len_reg);
        take      = !first && (run_reg >= need) && (!found_reg || better);
        run_start = ctl.idx - run_reg;
        hit_start = ctl.idx + SCAN_W'(1) - need;

        run_next        = run_reg;
        found_next      = found_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        res             = '0;

        if (ctl.init)
        begin
            run_next        = '0;
            found_next      = 1'b0;
            best_len_next   = '0;
            best_start_next = '0;
        end
        else if (ctl.step)
        begin
            if (!ctl.end_run)
            begin
                run_next = run_inc;
                // first fit stops at the first run long enough
                if (first && (run_inc == need))
                begin
                    res.done  = 1'b1;
                    res.found = 1'b1;
                    res.start = ADDR_W'(hit_start);
                end
            end
            else
            begin
                if (take)
                begin
                    found_next      = 1'b1;
                    best_len_next   = run_reg;
                    best_start_next = ADDR_W'(run_start);
                end
                run_next = '0;
                // pool end closes the trailing run too
                if (ctl.last)
                begin
                    res.done  = 1'b1;
                    res.found = found_reg || take;
                    res.start = take ? ADDR_W'(run_start) : best_start_reg;
                end
            end
        end
    end

    // Tracker registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg        <= '0;
            found_reg      <= 1'b0;
            best_len_reg   <= '0;
            best_start_reg <= '0;
        end
        else
        begin
            run_reg        <= run_next;
            found_reg      <= found_next;
            best_len_reg   <= best_len_next;
            best_start_reg <= best_start_next;
        end
    end

endmodule
